// ===== rtl/core/shmf_pkg.sv =====
// Package with the shared widths, codes and control types of the sales histogram core.
package shmf_pkg;

  // Fixed widths of the request and result fields.
  localparam int ARTICLE_W = 9;
  localparam int DAY_W     = 5;
  localparam int UNITS_W   = 16;
  localparam int BIN_W     = 32;
  localparam int GRAND_W   = 40;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  // Default sizes of the two histograms.
  localparam int DEF_NUM_ARTICLES = 256;
  localparam int DEF_NUM_DAYS     = 31;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD    = 2'd0,
    CMD_QUERY_ART = 2'd1,
    CMD_QUERY_DAY = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_BAD_ARTICLE = 2'd1,
    STAT_BAD_DAY     = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MULT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;        // clearing pass writes zero to both bin memories
    logic accept;       // capture a request and read its bins
    logic mult;         // register the mean-test product
    logic load_result;  // commit the request and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;   // last entry of the clearing pass
    logic out_free;     // result register can take a new result
    logic needs_mult;   // held request is a valid article query
  } dp_stat_t;

endpackage

// ===== rtl/core/sales_histogram_mean_filter_core.sv =====
// Top level of the sales histogram core with the mean filter on article queries.
//
//   Channel   Direction  Handshake            Payload
//   request   in         in_valid / in_stall  cmd, article, day, units
//   result    out        out_valid / out_stall status, bin_total, flag
//
// A record or day query first reads both bin memories, then loads the result
// register, a valid record also updating both bins. An article query with a valid
// code adds a registered total-times-count multiply before the compare; with a
// bad code it skips the multiply.
// After reset the block clears both bin memories one entry per cycle, with in_stall
// high, over max(NUM_ARTICLES, NUM_DAYS) entries.
// A new request is taken while an earlier result waits; a stalled result holds
// the block in its last step until the result register frees up.
module sales_histogram_mean_filter_core import shmf_pkg::*; #(
  parameter int NUM_ARTICLES = DEF_NUM_ARTICLES,
  parameter int NUM_DAYS     = DEF_NUM_DAYS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [ARTICLE_W-1:0] article,
  input  logic [DAY_W-1:0]     day,
  input  logic [UNITS_W-1:0]   units,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [BIN_W-1:0]     bin_total,
  output logic                 flag
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Controller.
  shmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  // Datapath.
  shmf_datapath #(
    .NUM_ARTICLES (NUM_ARTICLES),
    .NUM_DAYS     (NUM_DAYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .cmd       (cmd),
    .article   (article),
    .day       (day),
    .units     (units),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .bin_total (bin_total),
    .flag      (flag)
  );

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another was in flight");

  // A new result appears only at the end of a request's work.
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded with no request in flight");

  // No result is offered during the clearing pass.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.clear |-> !out_valid)
    else $error("result offered during the clearing pass");

  // Clearing and request work never overlap.
  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.clear |-> !(dp_cmd.accept || dp_cmd.load_result || dp_cmd.mult))
    else $error("request work during the clearing pass");

endmodule

// ===== rtl/core/shmf_ctrl.sv =====
// Controller state machine of the sales histogram core.
module shmf_ctrl import shmf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  ctl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        dp_cmd.clear = 1'b1;
        if (dp_stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.accept = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (dp_stat.needs_mult) begin
          dp_cmd.mult = 1'b1;
          state_next  = ST_MULT;
        end else if (dp_stat.out_free) begin
          dp_cmd.load_result = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      ST_MULT: begin
        if (dp_stat.out_free) begin
          dp_cmd.load_result = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/shmf_datapath.sv =====
// Datapath of the sales histogram core: bin memories, totals, mean test and result register.
module shmf_datapath import shmf_pkg::*; #(
  parameter int NUM_ARTICLES = DEF_NUM_ARTICLES,
  parameter int NUM_DAYS     = DEF_NUM_DAYS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              dp_cmd,
  output dp_stat_t             dp_stat,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [ARTICLE_W-1:0] article,
  input  logic [DAY_W-1:0]     day,
  input  logic [UNITS_W-1:0]   units,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [BIN_W-1:0]     bin_total,
  output logic                 flag
);

  localparam int AW    = $clog2(NUM_ARTICLES);
  localparam int DW    = (NUM_DAYS > 1) ? $clog2(NUM_DAYS) : 1;
  localparam int CNTW  = $clog2(NUM_ARTICLES + 1);
  localparam int PW    = BIN_W + CNTW;
  localparam int CMPW  = (PW > GRAND_W) ? PW : GRAND_W;
  localparam int SWEEP = (NUM_ARTICLES > NUM_DAYS) ? NUM_ARTICLES : NUM_DAYS;
  localparam int CW    = $clog2(SWEEP);

  // Bin memories.
  logic [BIN_W-1:0] art_mem [NUM_ARTICLES];
  logic [BIN_W-1:0] day_mem [NUM_DAYS];

  // Held request.
  cmd_t               cmd_q;
  logic               art_ok_q, day_ok_q;
  logic [UNITS_W-1:0] units_q;
  logic [AW-1:0]      art_idx_q;
  logic [DW-1:0]      day_idx_q;
  logic [BIN_W-1:0]   art_rd, day_rd;

  // Running totals, mean-test product and clearing counter.
  logic [GRAND_W-1:0] grand;
  logic [CNTW-1:0]    active;
  logic [PW-1:0]      prod;
  logic               nz_q;
  logic [CW-1:0]      clr_idx;

  // Input decode.
  logic                 art_ok_in, day_ok_in;
  logic [ARTICLE_W-1:0] art_m1;
  logic [DAY_W-1:0]     day_m1;
  logic [AW-1:0]        art_ra;
  logic [DW-1:0]        day_ra;

  assign art_ok_in = (article != '0) && (32'(article) <= NUM_ARTICLES);
  assign day_ok_in = (day != '0) && (32'(day) <= NUM_DAYS);
  assign art_m1    = article - ARTICLE_W'(1);
  assign day_m1    = day - DAY_W'(1);
  assign art_ra    = AW'(art_m1);
  assign day_ra    = DW'(day_m1);

  // Saturating bin updates. On saturation the grand total takes exactly the headroom
  // the article bin had left, which is the complement of the old value.
  logic [BIN_W:0]     art_sum, day_sum;
  logic [BIN_W-1:0]   art_new, day_new, art_delta;
  logic [GRAND_W:0]   grand_sum;
  logic               commit;

  assign art_sum   = {1'b0, art_rd} + (BIN_W + 1)'(units_q);
  assign day_sum   = {1'b0, day_rd} + (BIN_W + 1)'(units_q);
  assign art_new   = art_sum[BIN_W] ? '1 : art_sum[BIN_W-1:0];
  assign day_new   = day_sum[BIN_W] ? '1 : day_sum[BIN_W-1:0];
  assign art_delta = art_sum[BIN_W] ? ~art_rd : BIN_W'(units_q);
  assign grand_sum = {1'b0, grand} + (GRAND_W + 1)'(art_delta);
  assign commit    = dp_cmd.load_result && (cmd_q == CMD_RECORD) && art_ok_q && day_ok_q;

  // Memory write ports, shared by the clearing pass and record commits.
  logic             art_we, day_we;
  logic [AW-1:0]    art_wa;
  logic [DW-1:0]    day_wa;
  logic [BIN_W-1:0] art_wd, day_wd;

  always_comb begin
    if (dp_cmd.clear) begin
      art_we = 32'(clr_idx) < NUM_ARTICLES;
      day_we = 32'(clr_idx) < NUM_DAYS;
      art_wa = AW'(clr_idx);
      day_wa = DW'(clr_idx);
      art_wd = '0;
      day_wd = '0;
    end else begin
      art_we = commit;
      day_we = commit;
      art_wa = art_idx_q;
      day_wa = day_idx_q;
      art_wd = art_new;
      day_wd = day_new;
    end
  end

  // Article bin memory with registered read.
  always_ff @(posedge clk) begin
    if (art_we) begin
      art_mem[art_wa] <= art_wd;
    end
    if (dp_cmd.accept) begin
      art_rd <= art_mem[art_ra];
    end
  end

  // Day bin memory with registered read.
  always_ff @(posedge clk) begin
    if (day_we) begin
      day_mem[day_wa] <= day_wd;
    end
    if (dp_cmd.accept) begin
      day_rd <= day_mem[day_ra];
    end
  end

  // Request capture and mean-test product.
  always_ff @(posedge clk) begin
    if (dp_cmd.accept) begin
      cmd_q     <= cmd_t'(cmd);
      art_ok_q  <= art_ok_in;
      day_ok_q  <= day_ok_in;
      units_q   <= units;
      art_idx_q <= art_ra;
      day_idx_q <= day_ra;
    end
    if (dp_cmd.mult) begin
      prod <= PW'(art_rd) * PW'(active);
      nz_q <= active != '0;
    end
  end

  // Clearing counter, grand total and active article count.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      grand   <= '0;
      active  <= '0;
    end else begin
      if (dp_cmd.clear) begin
        clr_idx <= clr_idx + CW'(1);
      end
      if (commit) begin
        grand <= grand_sum[GRAND_W] ? '1 : grand_sum[GRAND_W-1:0];
        if ((art_rd == '0) && (art_new != '0)) begin
          active <= active + CNTW'(1);
        end
      end
    end
  end

  // Result selection.
  logic             cmp_gt;
  status_t          res_status;
  logic [BIN_W-1:0] res_total;
  logic             res_flag;

  assign cmp_gt = nz_q && (CMPW'(prod) > CMPW'(grand));

  always_comb begin
    res_status = STAT_OK;
    res_total  = '0;
    res_flag   = 1'b0;
    case (cmd_q)
      CMD_RECORD: begin
        if (!art_ok_q) begin
          res_status = STAT_BAD_ARTICLE;
        end else if (!day_ok_q) begin
          res_status = STAT_BAD_DAY;
        end else begin
          res_total = art_new;
        end
      end
      CMD_QUERY_ART: begin
        if (!art_ok_q) begin
          res_status = STAT_BAD_ARTICLE;
        end else begin
          res_total = art_rd;
          res_flag  = cmp_gt;
        end
      end
      CMD_QUERY_DAY: begin
        if (!day_ok_q) begin
          res_status = STAT_BAD_DAY;
        end else begin
          res_total = day_rd;
          res_flag  = day_rd == '0;
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_result) begin
      status    <= res_status;
      bin_total <= res_total;
      flag      <= res_flag;
    end
  end

  // Status to the controller.
  assign dp_stat.clear_last = clr_idx == CW'(SWEEP - 1);
  assign dp_stat.out_free   = !out_valid || !out_stall;
  assign dp_stat.needs_mult = (cmd_q == CMD_QUERY_ART) && art_ok_q;

endmodule
